### design/assert_macros.svh
// Assertion macros shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ACMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acmc assertion failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define ACMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acmc assertion failed");

`endif

### design/acmc_pkg.sv
// Shared constants, types and helpers of the counter-mode cipher.
package acmc_pkg;

  localparam int ROUNDS   = 8;
  localparam int PASSES   = (ROUNDS + 1) / 2;
  localparam int RK_DEPTH = 2 * PASSES;
  localparam int RK_AW    = $clog2(RK_DEPTH);
  localparam int RND_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int PASS_W   = (PASSES > 1) ? $clog2(PASSES) : 1;

  localparam logic [31:0] MUL0 = 32'h71e961dd;
  localparam logic [31:0] MUL1 = 32'h47dff15d;
  localparam logic [31:0] MUL2 = 32'h172f4f2f;
  localparam logic [31:0] MUL3 = 32'hf9c1e3c7;

  typedef enum logic [2:0] {
    CFG_KEY_WORD0     = 3'd0,
    CFG_KEY_WORD1     = 3'd1,
    CFG_KEY_WORD2     = 3'd2,
    CFG_KEY_WORD3     = 3'd3,
    CFG_NONCE_LOW     = 3'd4,
    CFG_NONCE_HIGH    = 3'd5,
    CFG_COUNTER_START = 3'd6
  } cfg_index_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_ROUND,
    ST_DONE
  } main_state_t;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_RUN,
    KX_WR0,
    KX_WR1
  } kx_state_t;

  typedef struct packed {
    logic             done;
    logic             we;
    logic [RK_AW-1:0] waddr;
    logic [127:0]     wdata;
  } kx_status_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

### design/acmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acmc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/acmc_keyexp.sv
// Key expansion sequencer: one whitening or mixing step per cycle, two round keys per pass.
module acmc_keyexp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [255:0]           key,
  output acmc_pkg::kx_status_t   status
);

  acmc_pkg::kx_state_t              state_r, state_nxt;
  logic [255:0]                     k_r, k_nxt;
  logic                             mix_r, mix_nxt;
  logic [acmc_pkg::RND_W-1:0]       rnd_r, rnd_nxt;
  logic [acmc_pkg::PASS_W-1:0]      pass_r, pass_nxt;

  function automatic logic [4:0] key_rot(input int i);
    logic [4:0] n;
    case (i)
      0:       n = 5'd17;
      1:       n = 5'd23;
      2:       n = 5'd7;
      3:       n = 5'd13;
      4:       n = 5'd29;
      5:       n = 5'd21;
      6:       n = 5'd19;
      default: n = 5'd15;
    endcase
    return n;
  endfunction

  function automatic logic [255:0] whiten_add(input logic [255:0] k);
    logic [255:0] w;
    logic [7:0]   b;
    logic [7:0]   x;
    for (int i = 0; i < 32; i++) begin
      b = k[8*i +: 8];
      w[8*i +: 8] = b ^ 8'(i) ^ {b[6:0], 1'b0} ^ {4'b0000, b[7:4]};
    end
    for (int g = 0; g < 8; g++) begin
      x = w[32*g +: 8] ^ w[32*g+8 +: 8] ^ w[32*g+16 +: 8] ^ w[32*g+24 +: 8];
      w[32*g +: 8] = w[32*g +: 8] + {x[2:0], x[7:3]};
    end
    return w;
  endfunction

  function automatic logic [255:0] mix_words(input logic [255:0] k);
    logic [255:0] t;
    logic [31:0]  s;
    for (int i = 0; i < 8; i++) begin
      s = (k[32*((i+1)&7) +: 32] ^ k[32*i +: 32]) + k[32*((i+7)&7) +: 32];
      t[32*i +: 32] = k[32*i +: 32] + acmc_pkg::rol32(s, key_rot(i));
    end
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acmc_pkg::KX_IDLE;
      mix_r   <= 1'b0;
      rnd_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mix_r   <= mix_nxt;
      rnd_r   <= rnd_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    mix_nxt      = mix_r;
    rnd_nxt      = rnd_r;
    pass_nxt     = pass_r;
    status.done  = 1'b0;
    status.we    = 1'b0;
    status.waddr = acmc_pkg::RK_AW'({pass_r, 1'b0});
    status.wdata = k_r[127:0];
    case (state_r)
      acmc_pkg::KX_IDLE: begin
        if (start) begin
          k_nxt     = key;
          mix_nxt   = 1'b0;
          rnd_nxt   = '0;
          pass_nxt  = '0;
          state_nxt = acmc_pkg::KX_RUN;
        end
      end
      acmc_pkg::KX_RUN: begin
        if (!mix_r) begin
          k_nxt   = whiten_add(k_r);
          mix_nxt = 1'b1;
        end else begin
          k_nxt   = mix_words(k_r);
          mix_nxt = 1'b0;
          if (rnd_r == acmc_pkg::RND_W'(acmc_pkg::ROUNDS - 1)) begin
            rnd_nxt   = '0;
            state_nxt = acmc_pkg::KX_WR0;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end
      end
      acmc_pkg::KX_WR0: begin
        status.we = 1'b1;
        state_nxt = acmc_pkg::KX_WR1;
      end
      acmc_pkg::KX_WR1: begin
        status.we    = 1'b1;
        status.waddr = acmc_pkg::RK_AW'({pass_r, 1'b1});
        status.wdata = k_r[255:128];
        if (pass_r == acmc_pkg::PASS_W'(acmc_pkg::PASSES - 1)) begin
          status.done = 1'b1;
          state_nxt   = acmc_pkg::KX_IDLE;
        end else begin
          pass_nxt  = pass_r + 1'b1;
          state_nxt = acmc_pkg::KX_RUN;
        end
      end
      default: begin
        state_nxt = acmc_pkg::KX_IDLE;
      end
    endcase
  end

endmodule

### design/arx_multiply_ctr_cipher_top.sv
// Top level of the counter-mode cipher: config registers, data round sequencer, output stage.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key, nonce and
//   counter_start; cfg_ready is always high. Write only while the block is idle.
//   in channel carries one item per beat: in_kind 0 is a start item (expand the key,
//   reload the block counter, no result), 1 is a data block of in_byte_count bytes, capped at 16.
//   out channel returns one beat per data block with a nonzero byte count; bytes at
//   or beyond out_result_count read as zero.
//   A data block runs each round through one shared add/rotate/multiply unit (four
//   add steps, four multiply steps), then waits in the DONE state until the output
//   register is free, where the result is registered and out_valid raised. in_ready
//   returns as the result is registered. The key expansion sequencer runs a start
//   item: per pass, a whiten step and a mix step for each round, then two round-key writes.
//   A block with byte count zero is accepted without leaving idle and gives no result.
//   Reset clears the config registers, the block counter and out_valid and returns
//   to idle; the round keys are undefined until a start item has run.
//   A stalled receiver holds the result in the output register; the next item is
//   still accepted and runs, and waits at its end until the output register frees.
`include "assert_macros.svh"

module arx_multiply_ctr_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_data_low,
  input  logic [63:0] in_data_high,
  input  logic [4:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  output logic [4:0]  out_result_count
);

  logic [63:0] key_word0_r, key_word1_r, key_word2_r, key_word3_r;
  logic [63:0] nonce_low_r;
  logic [31:0] nonce_high_r;
  logic [31:0] counter_start_r;

  acmc_pkg::main_state_t         state_r, state_nxt;
  logic [31:0]                   block_counter_r, block_counter_nxt;
  logic [3:0][31:0]              v_r, v_nxt;
  logic [2:0]                    phase_r, phase_nxt;
  logic [acmc_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  logic [63:0]                   data_low_r, data_low_nxt;
  logic [63:0]                   data_high_r, data_high_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [63:0]                   out_low_r, out_low_nxt;
  logic [63:0]                   out_high_r, out_high_nxt;
  logic [4:0]                    out_cnt_r, out_cnt_nxt;

  logic                          kx_start;
  acmc_pkg::kx_status_t          kx;
  logic [127:0]                  rk_rdata;
  logic [31:0]                   rk_word;
  logic [31:0]                   arx_sum;
  logic [31:0]                   mul_prod;
  logic [31:0]                   unit_out;
  logic [127:0]                  mask;
  logic [4:0]                    cnt_sat;

  function automatic logic [4:0] arx_rot(input logic [1:0] j);
    logic [4:0] n;
    case (j)
      2'd0:    n = 5'd13;
      2'd1:    n = 5'd7;
      2'd2:    n = 5'd11;
      default: n = 5'd15;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] mul_const(input logic [1:0] j);
    logic [31:0] c;
    case (j)
      2'd0:    c = acmc_pkg::MUL0;
      2'd1:    c = acmc_pkg::MUL1;
      2'd2:    c = acmc_pkg::MUL2;
      default: c = acmc_pkg::MUL3;
    endcase
    return c;
  endfunction

  function automatic logic [127:0] byte_mask(input logic [4:0] cnt);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) begin
      m[8*i +: 8] = (5'(i) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  acmc_keyexp u_keyexp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (kx_start),
    .key    ({key_word3_r, key_word2_r, key_word1_r, key_word0_r}),
    .status (kx)
  );

  acmc_ram #(
    .WIDTH (128),
    .DEPTH (acmc_pkg::RK_DEPTH)
  ) u_rk_ram (
    .clk   (clk),
    .we    (kx.we),
    .waddr (kx.waddr),
    .wdata (kx.wdata),
    .raddr (acmc_pkg::RK_AW'(rnd_r)),
    .rdata (rk_rdata)
  );

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == acmc_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_low   = out_low_r;
  assign out_result_high  = out_high_r;
  assign out_result_count = out_cnt_r;

  // shared unit: works on word 0, the state rotates one word per step
  assign rk_word  = rk_rdata[32*phase_r[1:0] +: 32];
  assign arx_sum  = acmc_pkg::rol32(v_r[0], arx_rot(phase_r[1:0])) + v_r[1] + v_r[2] + v_r[3];
  assign mul_prod = v_r[0] * mul_const(phase_r[1:0]);
  assign unit_out = phase_r[2] ? (mul_prod ^ rk_word) : arx_sum;
  assign mask     = byte_mask(cnt_r);
  assign cnt_sat  = (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word0_r     <= '0;
      key_word1_r     <= '0;
      key_word2_r     <= '0;
      key_word3_r     <= '0;
      nonce_low_r     <= '0;
      nonce_high_r    <= '0;
      counter_start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acmc_pkg::CFG_KEY_WORD0:     key_word0_r     <= cfg_data;
        acmc_pkg::CFG_KEY_WORD1:     key_word1_r     <= cfg_data;
        acmc_pkg::CFG_KEY_WORD2:     key_word2_r     <= cfg_data;
        acmc_pkg::CFG_KEY_WORD3:     key_word3_r     <= cfg_data;
        acmc_pkg::CFG_NONCE_LOW:     nonce_low_r     <= cfg_data;
        acmc_pkg::CFG_NONCE_HIGH:    nonce_high_r    <= cfg_data[31:0];
        acmc_pkg::CFG_COUNTER_START: counter_start_r <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= acmc_pkg::ST_IDLE;
      block_counter_r <= '0;
      out_valid_r     <= 1'b0;
      phase_r         <= '0;
      rnd_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      block_counter_r <= block_counter_nxt;
      out_valid_r     <= out_valid_nxt;
      phase_r         <= phase_nxt;
      rnd_r           <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    data_low_r  <= data_low_nxt;
    data_high_r <= data_high_nxt;
    cnt_r       <= cnt_nxt;
    out_low_r   <= out_low_nxt;
    out_high_r  <= out_high_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    block_counter_nxt = block_counter_r;
    v_nxt             = v_r;
    phase_nxt         = phase_r;
    rnd_nxt           = rnd_r;
    data_low_nxt      = data_low_r;
    data_high_nxt     = data_high_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_low_nxt       = out_low_r;
    out_high_nxt      = out_high_r;
    out_cnt_nxt       = out_cnt_r;
    kx_start          = 1'b0;
    case (state_r)
      acmc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == acmc_pkg::KIND_START) begin
            kx_start          = 1'b1;
            block_counter_nxt = counter_start_r;
            state_nxt         = acmc_pkg::ST_KEY;
          end else if (in_byte_count != 5'd0) begin
            v_nxt[0]          = nonce_low_r[31:0];
            v_nxt[1]          = nonce_low_r[63:32];
            v_nxt[2]          = nonce_high_r;
            v_nxt[3]          = block_counter_r;
            block_counter_nxt = block_counter_r + 32'd1;
            data_low_nxt      = in_data_low;
            data_high_nxt     = in_data_high;
            cnt_nxt           = cnt_sat;
            phase_nxt         = '0;
            rnd_nxt           = '0;
            state_nxt         = acmc_pkg::ST_ROUND;
          end
        end
      end
      acmc_pkg::ST_KEY: begin
        if (kx.done) begin
          state_nxt = acmc_pkg::ST_IDLE;
        end
      end
      acmc_pkg::ST_ROUND: begin
        v_nxt     = {unit_out, v_r[3], v_r[2], v_r[1]};
        phase_nxt = phase_r + 3'd1;
        if (phase_r == 3'd7) begin
          if (rnd_r == acmc_pkg::RND_W'(acmc_pkg::ROUNDS - 1)) begin
            rnd_nxt   = '0;
            state_nxt = acmc_pkg::ST_DONE;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end
      end
      acmc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = (data_low_r ^ {v_r[1], v_r[0]}) & mask[63:0];
          out_high_nxt  = (data_high_r ^ {v_r[3], v_r[2]}) & mask[127:64];
          out_cnt_nxt   = cnt_r;
          state_nxt     = acmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acmc_pkg::ST_IDLE;
      end
    endcase
  end

  `ACMC_ASSERT_NOW(a_kx_write_in_key, kx.we, state_r == acmc_pkg::ST_KEY)
  `ACMC_ASSERT_NOW(a_kx_done_in_key, kx.done, state_r == acmc_pkg::ST_KEY)
  `ACMC_ASSERT_NEXT(a_done_holds_on_stall,
                    (state_r == acmc_pkg::ST_DONE) && out_valid_r && !out_ready,
                    state_r == acmc_pkg::ST_DONE)
  `ACMC_ASSERT_NEXT(a_counter_advances,
                    in_valid && in_ready && (in_kind == acmc_pkg::KIND_DATA) && (in_byte_count != 5'd0),
                    block_counter_r == 32'($past(block_counter_r) + 32'd1))
  `ACMC_ASSERT_NOW(a_out_count_range, out_valid,
                   (out_result_count != 5'd0) && (out_result_count <= 5'd16))

endmodule

### verif/cipher_sb_pkg.sv
// Scoreboard class for the counter-mode cipher: predicts result beats and checks them.
package cipher_sb_pkg;
  import acmc_pkg::*;

  localparam int N_ROUNDS  = acmc_pkg::ROUNDS;
  localparam int N_PASSES  = (N_ROUNDS + 1) / 2;
  localparam int KEY_SLOTS = 2 * N_PASSES;

  localparam logic [31:0] MIX_MUL0 = 32'h71e961dd;
  localparam logic [31:0] MIX_MUL1 = 32'h47dff15d;
  localparam logic [31:0] MIX_MUL2 = 32'h172f4f2f;
  localparam logic [31:0] MIX_MUL3 = 32'hf9c1e3c7;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  cnt;
  } cipher_beat_t;

  class cipher_scoreboard;
    logic [63:0]  key_reg [4];
    logic [63:0]  nonce_low;
    logic [31:0]  nonce_high;
    logic [31:0]  counter_init;
    logic [31:0]  block_ctr;
    logic [31:0]  sched_key [KEY_SLOTS][4];
    cipher_beat_t expected_q [$];
    int errors;
    int key_loads;
    int blocks_in;
    int partial_blocks;
    int empty_blocks;
    int checked;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      foreach (sched_key[i, j]) sched_key[i][j] = '0;
      nonce_low = '0;
      nonce_high = '0;
      counter_init = '0;
      block_ctr = '0;
      errors = 0;
      key_loads = 0;
      blocks_in = 0;
      partial_blocks = 0;
      empty_blocks = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    static function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void write_reg(cfg_index_t idx, logic [63:0] val);
      case (idx)
        CFG_KEY_WORD0: begin
          key_reg[0] = val;
        end
        CFG_KEY_WORD1: begin
          key_reg[1] = val;
        end
        CFG_KEY_WORD2: begin
          key_reg[2] = val;
        end
        CFG_KEY_WORD3: begin
          key_reg[3] = val;
        end
        CFG_NONCE_LOW: begin
          nonce_low = val;
        end
        CFG_NONCE_HIGH: begin
          nonce_high = val[31:0];
        end
        CFG_COUNTER_START: begin
          counter_init = val[31:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void expand_key();
      logic [7:0]  k [32];
      logic [31:0] v [8];
      logic [31:0] t [8];
      logic [31:0] b;
      logic [7:0]  x;
      int unsigned rot_amt [8] = '{17, 23, 7, 13, 29, 21, 19, 15};
      for (int i = 0; i < 32; i++) k[i] = key_reg[i / 8][8 * (i % 8) +: 8];
      for (int p = 0; p < N_PASSES; p++) begin
        for (int r = 0; r < N_ROUNDS; r++) begin
          for (int i = 0; i < 32; i++) begin
            b = {24'd0, k[i]};
            k[i] = k[i] ^ 8'(32'(i) ^ (b << 1) ^ (b >> 4));
          end
          for (int i = 0; i < 32; i += 4) begin
            x = k[i] ^ k[i + 1] ^ k[i + 2] ^ k[i + 3];
            k[i] = k[i] + {x[2:0], x[7:3]};
          end
          for (int i = 0; i < 8; i++) begin
            v[i] = {k[4 * i + 3], k[4 * i + 2], k[4 * i + 1], k[4 * i]};
            t[i] = v[i];
          end
          for (int i = 0; i < 8; i++)
            t[i] += rotl((v[(i + 1) % 8] ^ v[i]) + v[(i + 7) % 8], rot_amt[i]);
          for (int i = 0; i < 8; i++)
            {k[4 * i + 3], k[4 * i + 2], k[4 * i + 1], k[4 * i]} = t[i];
        end
        for (int j = 0; j < 4; j++) begin
          sched_key[2 * p][j] = {k[4 * j + 3], k[4 * j + 2], k[4 * j + 1], k[4 * j]};
          sched_key[2 * p + 1][j] =
            {k[16 + 4 * j + 3], k[16 + 4 * j + 2], k[16 + 4 * j + 1], k[16 + 4 * j]};
        end
      end
    endfunction

    function void note_input(item_kind_t kind, logic [63:0] lo, logic [63:0] hi,
                             logic [4:0] cnt_in);
      logic [31:0]  v0, v1, v2, v3, u, pr;
      logic [63:0]  rlo, rhi;
      int unsigned  cnt;
      cipher_beat_t beat;
      if (kind == KIND_START) begin
        expand_key();
        block_ctr = counter_init;
        key_loads++;
        return;
      end
      cnt = cnt_in;
      if (cnt == 0) begin
        empty_blocks++;
        return;
      end
      if (cnt > 16) cnt = 16;
      v0 = nonce_low[31:0];
      v1 = nonce_low[63:32];
      v2 = nonce_high;
      v3 = block_ctr;
      for (int r = 0; r < N_ROUNDS; r++) begin
        u  = v2 + v3;
        v0 = rotl(v0, 13) + v1 + u;
        v1 = rotl(v1, 7) + u + v0;
        pr = v0 + v1;
        v2 = rotl(v2, 11) + v3 + pr;
        v3 = rotl(v3, 15) + pr + v2;
        v0 = (v0 * MIX_MUL0) ^ sched_key[r][0];
        v1 = (v1 * MIX_MUL1) ^ sched_key[r][1];
        v2 = (v2 * MIX_MUL2) ^ sched_key[r][2];
        v3 = (v3 * MIX_MUL3) ^ sched_key[r][3];
      end
      rlo = lo ^ {v1, v0};
      rhi = hi ^ {v3, v2};
      if (cnt < 8) begin
        rlo &= (64'd1 << (8 * cnt)) - 64'd1;
        rhi = '0;
      end else if (cnt < 16) begin
        rhi &= (64'd1 << (8 * (cnt - 8))) - 64'd1;
      end
      block_ctr = block_ctr + 32'd1;
      beat.lo = rlo;
      beat.hi = rhi;
      beat.cnt = 5'(cnt);
      expected_q.push_back(beat);
      blocks_in++;
      if (cnt < 16) partial_blocks++;
    endfunction

    function void check_output(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt);
      cipher_beat_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result beat with no block pending: low %h high %h count %0d", lo, hi, cnt);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (lo !== want.lo) begin
        $error("result_low: expected %h, got %h", want.lo, lo);
        errors++;
      end
      if (hi !== want.hi) begin
        $error("result_high: expected %h, got %h", want.hi, hi);
        errors++;
      end
      if (cnt !== want.cnt) begin
        $error("result_count: expected %0d, got %0d", want.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

endpackage

### verif/tb.sv
// Testbench top for the counter-mode cipher: directed and random traffic, scoreboard checks.
module tb;
  import acmc_pkg::*;
  import cipher_sb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_KEY_WORD0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  item_kind_t  in_kind = KIND_START;
  logic [63:0] in_data_low = '0;
  logic [63:0] in_data_high = '0;
  logic [4:0]  in_byte_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic [4:0]  out_result_count;

  cipher_scoreboard sb;
  int send_seq;
  int recv_seq;

  arx_multiply_ctr_cipher_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_data_low      (in_data_low),
    .in_data_high     (in_data_high),
    .in_byte_count    (in_byte_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_low   (out_result_low),
    .out_result_high  (out_result_high),
    .out_result_count (out_result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // busy stretches with no idling, then calmer ones with random idle gaps
  function automatic int idle_cycles(int seq);
    if (((seq / 40) % 3) == 0) return 0;
    return $urandom_range(12, 0);
  endfunction

  task automatic cfg_write(cfg_index_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
  endtask

  task automatic load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [63:0] nlo, logic [31:0] nhi,
                               logic [31:0] ctr);
    cfg_write(CFG_KEY_WORD0, k0);
    cfg_write(CFG_KEY_WORD1, k1);
    cfg_write(CFG_KEY_WORD2, k2);
    cfg_write(CFG_KEY_WORD3, k3);
    cfg_write(CFG_NONCE_LOW, nlo);
    cfg_write(CFG_NONCE_HIGH, {$urandom, nhi});
    cfg_write(CFG_COUNTER_START, {$urandom, ctr});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(item_kind_t kind, logic [63:0] lo, logic [63:0] hi,
                           logic [4:0] cnt);
    int gap;
    gap = idle_cycles(send_seq);
    send_seq++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_data_low   <= lo;
    in_data_high  <= hi;
    in_byte_count <= cnt;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(kind, lo, hi, cnt);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [4:0]  cnt;
    logic [63:0] lo;
    logic [63:0] hi;
    lo = rand64();
    hi = rand64();
    if ($urandom_range(99, 0) < 3) begin
      send_item(KIND_START, lo, hi, 5'($urandom));
      return;
    end
    pick = $urandom_range(99, 0);
    if (pick < 65) cnt = 5'd16;
    else if (pick < 88) cnt = 5'($urandom_range(15, 1));
    else if (pick < 94) cnt = 5'($urandom_range(31, 17));
    else cnt = 5'd0;
    pick = $urandom_range(99, 0);
    if (pick < 3) begin
      lo = '1;
      hi = '1;
    end else if (pick < 6) begin
      lo = '0;
      hi = '0;
    end
    send_item(KIND_DATA, lo, hi, cnt);
  endtask

  // drain, then let a trailing key expansion finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (100) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_output(out_result_low, out_result_high, out_result_count);
  end

  initial begin
    int gap;
    recv_seq = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        recv_seq++;
        gap = (recv_seq == 150 || recv_seq == 650) ? 400 : idle_cycles(recv_seq);
        if (gap > 0) begin
          out_ready <= 1'b0;
          do @(posedge clk); while (!out_valid);
          repeat (gap - 1) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("** arx_multiply_ctr_cipher_top: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    send_seq = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings('1, '1, '1, '1, '1, '1, 32'hffffffff);
    send_item(KIND_START, '1, '1, 5'd31);
    send_item(KIND_DATA, '1, '1, 5'd16);
    send_item(KIND_DATA, rand64(), rand64(), 5'd0);
    send_item(KIND_DATA, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd1);
    send_item(KIND_DATA, rand64(), rand64(), 5'd7);
    send_item(KIND_DATA, rand64(), rand64(), 5'd8);
    send_item(KIND_DATA, rand64(), rand64(), 5'd9);
    send_item(KIND_DATA, rand64(), rand64(), 5'd15);
    send_item(KIND_DATA, '0, '0, 5'd16);
    send_item(KIND_DATA, rand64(), rand64(), 5'd17);
    send_item(KIND_DATA, '1, '1, 5'd31);
    send_item(KIND_START, '0, '0, 5'd0);
    send_item(KIND_DATA, rand64(), rand64(), 5'd16);
    send_item(KIND_DATA, rand64(), rand64(), 5'd12);
    send_item(KIND_START, '1, '1, 5'd16);
    send_item(KIND_DATA, rand64(), rand64(), 5'd4);
    send_item(KIND_DATA, rand64(), rand64(), 5'd0);
    send_item(KIND_DATA, rand64(), rand64(), 5'd16);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          load_settings('0, '0, '0, '0, '0, '0, '0);
        end
        1: begin
          load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                        32'hffffffff - $urandom_range(40, 0));
        end
        2: begin
          load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                        $urandom);
        end
        default: begin
          load_settings('1, '1, '1, '1, rand64(), $urandom, $urandom);
        end
      endcase
      send_item(KIND_START, rand64(), rand64(), 5'd16);
      for (int n = 0; n < 240; n++) begin
        if (ph == 2 && n == 120) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_random_item();
      end
      settle();
    end

    $display("Run covered %0d key loads and %0d data blocks (%0d partial, %0d empty);",
             sb.key_loads, sb.blocks_in, sb.partial_blocks, sb.empty_blocks);
    $display("%0d result beats checked over five key, nonce and counter settings.",
             sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** arx_multiply_ctr_cipher_top: PASSED **");
    end else begin
      $display("** arx_multiply_ctr_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/acmc_pkg.sv
design/acmc_ram.sv
design/acmc_keyexp.sv
design/arx_multiply_ctr_cipher_top.sv
verif/cipher_sb_pkg.sv
verif/tb.sv
